// ----- sv/ucp_pkg.sv -----
package ucp_pkg;

	// Coordinate format
	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int XI_W      = 17;

	// Square root chain: radicand bits, root bits, partial remainder bits
	localparam int RAD_W    = 66;
	localparam int ROOT_W   = RAD_W / 2;
	localparam int SQ_REM_W = ROOT_W + 2;

	// Divider chain: divisor bits, quotient bits, numerator bits
	localparam int DIV_W = 64;
	localparam int QUO_W = 41;
	localparam int NUM_W = 82;

	// Operation codes
	localparam logic [1:0] MODE_PROJECT = 2'd0;
	localparam logic [1:0] MODE_SPHERE  = 2'd1;
	localparam logic [1:0] MODE_LIFT    = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_SAT     = 2'd2;

	// Side data that rides along the square root chain
	typedef struct packed {
		logic [1:0]          mode;
		logic                inval;
		logic                neg_a;
		logic                neg_b;
		logic                neg_c;
		logic [COORD_W-1:0]  a_mag;
		logic [COORD_W-1:0]  b_mag;
		logic [COORD_W-1:0]  c_mag;
		logic signed [COORD_W-1:0] c_val;
		logic [63:0]         r2;
	} sq_side_t;

	// One lane of the divider chain
	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [QUO_W-1:0] low;
		logic [QUO_W-1:0] quo;
	} div_lane_t;

	// Side data that rides along the divider chain
	typedef struct packed {
		logic [1:0] mode;
		logic       inval;
		logic       neg_x;
		logic       neg_y;
		logic       neg_z;
		logic [2:0] ovf;
	} div_side_t;

	// Result transaction
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [1:0]                status;
	} res_t;

endpackage

// ----- sv/unified_camera_projection.sv -----
// Unified-sphere camera unit, Q16.16 fixed point.
// Input channel: in_valid / in_stall with mode, coord_a, coord_b, coord_c.
//   mode 0 projects a 3D point to normalized image coordinates, mode 1 scales
//   it onto the unit sphere, mode 2 lifts image coordinates onto the sphere.
// Output channel: out_valid / out_stall with out_x, out_y, out_z, status
//   (0 ok, 1 invalid input, 2 saturated). Exactly one result per transaction,
//   in order.
// Configuration: cfg_we / cfg_wdata write mirror_xi (unsigned Q1.16); change
//   it only while no transaction is in flight.
// Throughput: one transaction per cycle while in_stall is low. Pipeline: five
//   front stages, a 33-cell square root chain, three stages for the scale
//   products, a 41-cell divider chain and the output register.
// Reset: clears every valid bit and loads mirror_xi with 1.0.
// Stall: when the receiver stalls, the pipeline still moves one more
//   transaction into a skid entry; once that entry is full, in_stall rises
//   and the whole pipeline holds until the receiver takes the output.
module unified_camera_projection import ucp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [XI_W-1:0]           cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                mode,
	input  logic signed [COORD_W-1:0] coord_a,
	input  logic signed [COORD_W-1:0] coord_b,
	input  logic signed [COORD_W-1:0] coord_c,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [COORD_W-1:0] out_x,
	output logic signed [COORD_W-1:0] out_y,
	output logic signed [COORD_W-1:0] out_z,
	output logic [1:0]                status
);

	logic [XI_W-1:0]   mirror_xi_q;
	logic              en;
	logic              buf_full;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_xi_q <= XI_W'(1 << FRAC_BITS);
		end else if (cfg_we) begin
			mirror_xi_q <= cfg_wdata;
		end
	end

	assign en       = !buf_full;
	assign in_stall = buf_full;

	// ---------------- s1: magnitudes and signs ----------------
	logic                      valid_s1;
	logic [1:0]                mode_s1;
	logic                      neg_a_s1, neg_b_s1, neg_c_s1;
	logic [COORD_W-1:0]        a_mag_s1, b_mag_s1, c_mag_s1;
	logic signed [COORD_W-1:0] c_val_s1;
	logic [COORD_W-1:0]        a_abs, b_abs, c_abs;

	assign a_abs = coord_a[COORD_W-1] ? -coord_a : coord_a;
	assign b_abs = coord_b[COORD_W-1] ? -coord_b : coord_b;
	assign c_abs = coord_c[COORD_W-1] ? -coord_c : coord_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1  <= mode;
			neg_a_s1 <= coord_a[COORD_W-1];
			neg_b_s1 <= coord_b[COORD_W-1];
			neg_c_s1 <= coord_c[COORD_W-1];
			a_mag_s1 <= a_abs;
			b_mag_s1 <= b_abs;
			c_mag_s1 <= c_abs;
			c_val_s1 <= coord_c;
		end
	end

	// ---------------- s2: squares ----------------
	logic                      valid_s2;
	logic [1:0]                mode_s2;
	logic                      neg_a_s2, neg_b_s2, neg_c_s2;
	logic [COORD_W-1:0]        a_mag_s2, b_mag_s2, c_mag_s2;
	logic signed [COORD_W-1:0] c_val_s2;
	logic [63:0]               a2_s2, b2_s2, c2_s2;
	logic [2*XI_W-1:0]         xi2_s2;
	logic [63:0]               a2_d, b2_d, c2_d;
	logic [2*XI_W-1:0]         xi2_d;

	assign a2_d  = a_mag_s1 * a_mag_s1;
	assign b2_d  = b_mag_s1 * b_mag_s1;
	assign c2_d  = c_mag_s1 * c_mag_s1;
	assign xi2_d = mirror_xi_q * mirror_xi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2  <= mode_s1;
			neg_a_s2 <= neg_a_s1;
			neg_b_s2 <= neg_b_s1;
			neg_c_s2 <= neg_c_s1;
			a_mag_s2 <= a_mag_s1;
			b_mag_s2 <= b_mag_s1;
			c_mag_s2 <= c_mag_s1;
			c_val_s2 <= c_val_s1;
			a2_s2    <= a2_d;
			b2_s2    <= b2_d;
			c2_s2    <= c2_d;
			xi2_s2   <= xi2_d;
		end
	end

	// ---------------- s3: sums of squares, 1 - xi^2 ----------------
	logic                      valid_s3;
	logic [1:0]                mode_s3;
	logic                      neg_a_s3, neg_b_s3, neg_c_s3;
	logic [COORD_W-1:0]        a_mag_s3, b_mag_s3, c_mag_s3;
	logic signed [COORD_W-1:0] c_val_s3;
	logic [63:0]               r2_s3, s_s3;
	logic                      kneg_s3;
	logic [2*XI_W:0]           kmag_s3;
	logic [63:0]               r2_d;
	logic signed [2*XI_W+1:0]  k_d;
	logic [2*XI_W+1:0]         k_abs;

	assign r2_d  = 64'(a2_s2 + b2_s2);
	assign k_d   = $signed((2*XI_W+2)'(1) << (2*FRAC_BITS)) - $signed({2'b00, xi2_s2});
	assign k_abs = k_d[2*XI_W+1] ? -k_d : k_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3  <= mode_s2;
			neg_a_s3 <= neg_a_s2;
			neg_b_s3 <= neg_b_s2;
			neg_c_s3 <= neg_c_s2;
			a_mag_s3 <= a_mag_s2;
			b_mag_s3 <= b_mag_s2;
			c_mag_s3 <= c_mag_s2;
			c_val_s3 <= c_val_s2;
			r2_s3    <= r2_d;
			s_s3     <= 64'(r2_d + c2_s2);
			kneg_s3  <= k_d[2*XI_W+1];
			kmag_s3  <= k_abs[2*XI_W:0];
		end
	end

	// ---------------- s4: (1 - xi^2) * r2 as two partial products ----------------
	logic                      valid_s4;
	logic [1:0]                mode_s4;
	logic                      neg_a_s4, neg_b_s4, neg_c_s4;
	logic [COORD_W-1:0]        a_mag_s4, b_mag_s4, c_mag_s4;
	logic signed [COORD_W-1:0] c_val_s4;
	logic [63:0]               r2_s4, s_s4;
	logic                      kneg_s4;
	logic [2*XI_W+32:0]        plo_s4, phi_s4;
	logic [2*XI_W+32:0]        plo_d, phi_d;

	assign plo_d = kmag_s3 * r2_s3[31:0];
	assign phi_d = kmag_s3 * r2_s3[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s4  <= mode_s3;
			neg_a_s4 <= neg_a_s3;
			neg_b_s4 <= neg_b_s3;
			neg_c_s4 <= neg_c_s3;
			a_mag_s4 <= a_mag_s3;
			b_mag_s4 <= b_mag_s3;
			c_mag_s4 <= c_mag_s3;
			c_val_s4 <= c_val_s3;
			r2_s4    <= r2_s3;
			s_s4     <= s_s3;
			kneg_s4  <= kneg_s3;
			plo_s4   <= plo_d;
			phi_s4   <= phi_d;
		end
	end

	// ---------------- s5: radicand select ----------------
	logic             valid_s5;
	sq_side_t         side_s5;
	logic [RAD_W-1:0] rad_s5;
	logic [RAD_W-1:0] term_d;
	logic [RAD_W-1:0] one_d;
	logic [RAD_W-1:0] rad_d;
	logic             bad_d;
	sq_side_t         side_d;

	assign term_d = RAD_W'(phi_s4 + (plo_s4 >> 32));
	assign one_d  = RAD_W'(1) << (2*FRAC_BITS);

	always_comb begin
		bad_d = 1'b0;
		rad_d = RAD_W'(s_s4);
		if (mode_s4 == MODE_LIFT) begin
			priority if (!kneg_s4) begin
				rad_d = RAD_W'(one_d + term_d);
			end else if (term_d <= one_d) begin
				rad_d = RAD_W'(one_d - term_d);
			end else begin
				bad_d = 1'b1;
				rad_d = '0;
			end
		end
		side_d.mode  = mode_s4;
		side_d.inval = bad_d || (mode_s4 != MODE_PROJECT && mode_s4 != MODE_SPHERE
			&& mode_s4 != MODE_LIFT);
		side_d.neg_a = neg_a_s4;
		side_d.neg_b = neg_b_s4;
		side_d.neg_c = neg_c_s4;
		side_d.a_mag = a_mag_s4;
		side_d.b_mag = b_mag_s4;
		side_d.c_mag = c_mag_s4;
		side_d.c_val = c_val_s4;
		side_d.r2    = r2_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_d;
			rad_s5  <= rad_d;
		end
	end

	// ---------------- square root chain ----------------
	logic                sq_valid [ROOT_W+1];
	sq_side_t            sq_side  [ROOT_W+1];
	logic [RAD_W-1:0]    sq_rad   [ROOT_W+1];
	logic [SQ_REM_W-1:0] sq_rem   [ROOT_W+1];
	logic [ROOT_W-1:0]   sq_root  [ROOT_W+1];

	assign sq_valid[0] = valid_s5;
	assign sq_side[0]  = side_s5;
	assign sq_rad[0]   = rad_s5;
	assign sq_rem[0]   = '0;
	assign sq_root[0]  = '0;

	for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
		ucp_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_i  (sq_valid[g]),
			.side_i   (sq_side[g]),
			.rad_i    (sq_rad[g]),
			.rem_i    (sq_rem[g]),
			.root_i   (sq_root[g]),
			.valid_s1 (sq_valid[g+1]),
			.side_s1  (sq_side[g+1]),
			.rad_s1   (sq_rad[g+1]),
			.rem_s1   (sq_rem[g+1]),
			.root_s1  (sq_root[g+1])
		);
	end

	// ---------------- s6: xi * norm, xi + root ----------------
	logic                     valid_s6;
	sq_side_t                 side_s6;
	logic [ROOT_W-1:0]        root_s6;
	logic [XI_W+ROOT_W-1:0]   prod_s6;
	logic [ROOT_W:0]          n_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= sq_valid[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= sq_side[ROOT_W];
			root_s6 <= sq_root[ROOT_W];
			prod_s6 <= mirror_xi_q * sq_root[ROOT_W];
			n_s6    <= (ROOT_W+1)'(mirror_xi_q) + (ROOT_W+1)'(sq_root[ROOT_W]);
		end
	end

	// ---------------- s7: denominator, lift numerators ----------------
	localparam int DEN_W = ROOT_W + 3;
	localparam int PN_W  = COORD_W + ROOT_W + 1;

	logic                    valid_s7;
	sq_side_t                side_s7;
	logic [ROOT_W-1:0]       root_s7;
	logic [ROOT_W:0]         n_s7;
	logic signed [DEN_W-1:0] den_s7;
	logic [PN_W-1:0]         pa_s7, pb_s7;
	logic signed [DEN_W-1:0] den_d;

	assign den_d = DEN_W'(side_s6.c_val)
		+ $signed({2'b00, prod_s6[XI_W+ROOT_W-1:FRAC_BITS]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= side_s6;
			root_s7 <= root_s6;
			n_s7    <= n_s6;
			den_s7  <= den_d;
			pa_s7   <= side_s6.a_mag * n_s6;
			pb_s7   <= side_s6.b_mag * n_s6;
		end
	end

	// ---------------- s8: divisor and numerators ----------------
	logic             valid_s8;
	div_side_t        dside_s8;
	logic [DIV_W-1:0] dvs_s8;
	div_lane_t [2:0]  lane_s8;
	logic             den_neg;
	logic [DEN_W-1:0] den_mag;
	logic [DIV_W-1:0] dvs_d;
	logic [NUM_W-1:0] num_d [3];
	logic             inval_d;
	div_side_t        dside_d;
	div_lane_t [2:0]  lane_d;

	assign den_neg = den_s7[DEN_W-1];
	assign den_mag = den_neg ? -den_s7 : den_s7;

	always_comb begin
		inval_d = side_s7.inval;
		dvs_d   = DIV_W'(root_s7);
		num_d[0] = {(NUM_W-COORD_W-FRAC_BITS)'(0), side_s7.a_mag, FRAC_BITS'(0)};
		num_d[1] = {(NUM_W-COORD_W-FRAC_BITS)'(0), side_s7.b_mag, FRAC_BITS'(0)};
		num_d[2] = {(NUM_W-COORD_W-FRAC_BITS)'(0), side_s7.c_mag, FRAC_BITS'(0)};
		unique case (side_s7.mode)
			MODE_PROJECT: begin
				dvs_d    = DIV_W'(den_mag);
				num_d[2] = '0;
				inval_d  = inval_d || (den_s7 == '0);
			end
			MODE_SPHERE: begin
				inval_d = inval_d || (root_s7 == '0);
			end
			MODE_LIFT: begin
				dvs_d    = DIV_W'(side_s7.r2 + (DIV_W'(1) << (2*FRAC_BITS)));
				num_d[0] = NUM_W'({pa_s7, FRAC_BITS'(0)});
				num_d[1] = NUM_W'({pb_s7, FRAC_BITS'(0)});
				num_d[2] = NUM_W'({n_s7, (2*FRAC_BITS)'(0)});
			end
			default: begin
				inval_d = 1'b1;
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			lane_d[i].rem = DIV_W'(num_d[i][NUM_W-1:QUO_W]);
			lane_d[i].low = num_d[i][QUO_W-1:0];
			lane_d[i].quo = '0;
			dside_d.ovf[i] = (DIV_W'(num_d[i][NUM_W-1:QUO_W]) >= dvs_d);
		end
		dside_d.mode  = side_s7.mode;
		dside_d.inval = inval_d;
		dside_d.neg_x = (side_s7.mode == MODE_PROJECT) ? (side_s7.neg_a ^ den_neg)
			: side_s7.neg_a;
		dside_d.neg_y = (side_s7.mode == MODE_PROJECT) ? (side_s7.neg_b ^ den_neg)
			: side_s7.neg_b;
		dside_d.neg_z = side_s7.neg_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dside_s8 <= dside_d;
			dvs_s8   <= dvs_d;
			lane_s8  <= lane_d;
		end
	end

	// ---------------- divider chain ----------------
	logic             dv_valid [QUO_W+1];
	div_side_t        dv_side  [QUO_W+1];
	logic [DIV_W-1:0] dv_dvs   [QUO_W+1];
	div_lane_t [2:0]  dv_lane  [QUO_W+1];

	assign dv_valid[0] = valid_s8;
	assign dv_side[0]  = dside_s8;
	assign dv_dvs[0]   = dvs_s8;
	assign dv_lane[0]  = lane_s8;

	for (genvar g = 0; g < QUO_W; g++) begin : g_div
		ucp_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_i  (dv_valid[g]),
			.side_i   (dv_side[g]),
			.dvs_i    (dv_dvs[g]),
			.lane_i   (dv_lane[g]),
			.valid_s1 (dv_valid[g+1]),
			.side_s1  (dv_side[g+1]),
			.dvs_s1   (dv_dvs[g+1]),
			.lane_s1  (dv_lane[g+1])
		);
	end

	// ---------------- result formatting ----------------
	function automatic logic [COORD_W:0] clamp_q(input logic [QUO_W-1:0] q,
		input logic ovf, input logic neg);
		logic [QUO_W-1:0]   lim;
		logic               sat;
		logic [COORD_W-1:0] v;
		lim = neg ? (QUO_W'(1) << (COORD_W-1)) : ((QUO_W'(1) << (COORD_W-1)) - QUO_W'(1));
		sat = ovf || (q > lim);
		v   = sat ? lim[COORD_W-1:0] : q[COORD_W-1:0];
		return {sat, neg ? (~v + COORD_W'(1)) : v};
	endfunction

	localparam logic [QUO_W-1:0] FACT_MAX = QUO_W'(1) << (QUO_W-1);

	div_side_t                 fside;
	div_lane_t [2:0]           flane;
	logic [COORD_W:0]          cx, cy, cz;
	logic [QUO_W-1:0]          fz;
	logic signed [QUO_W:0]     zz;
	logic signed [COORD_W-1:0] z_lift;
	logic                      sat_lift;
	res_t                      res_d;

	assign fside = dv_side[QUO_W];
	assign flane = dv_lane[QUO_W];
	assign cx    = clamp_q(flane[0].quo, fside.ovf[0], fside.neg_x);
	assign cy    = clamp_q(flane[1].quo, fside.ovf[1], fside.neg_y);
	assign cz    = clamp_q(flane[2].quo, fside.ovf[2], fside.neg_z);

	// Lift mode: z = fact - xi with fact capped, then saturate to 32 bits
	always_comb begin
		fz = (fside.ovf[2] || flane[2].quo > FACT_MAX) ? FACT_MAX : flane[2].quo;
		zz = $signed({1'b0, fz}) - $signed((QUO_W+1)'(mirror_xi_q));
		priority if (zz > $signed((QUO_W+1)'({1'b0, {(COORD_W-1){1'b1}}}))) begin
			z_lift   = {1'b0, {(COORD_W-1){1'b1}}};
			sat_lift = 1'b1;
		end else if (zz < -$signed((QUO_W+1)'(1) << (COORD_W-1))) begin
			z_lift   = {1'b1, {(COORD_W-1){1'b0}}};
			sat_lift = 1'b1;
		end else begin
			z_lift   = zz[COORD_W-1:0];
			sat_lift = 1'b0;
		end
	end

	always_comb begin
		res_d.x      = cx[COORD_W-1:0];
		res_d.y      = cy[COORD_W-1:0];
		res_d.z      = '0;
		res_d.status = ST_OK;
		priority if (fside.inval) begin
			res_d.x      = '0;
			res_d.y      = '0;
			res_d.status = ST_INVALID;
		end else if (fside.mode == MODE_PROJECT) begin
			res_d.status = (cx[COORD_W] || cy[COORD_W]) ? ST_SAT : ST_OK;
		end else if (fside.mode == MODE_SPHERE) begin
			res_d.z      = cz[COORD_W-1:0];
			res_d.status = (cx[COORD_W] || cy[COORD_W] || cz[COORD_W]) ? ST_SAT : ST_OK;
		end else begin
			res_d.z      = z_lift;
			res_d.status = (cx[COORD_W] || cy[COORD_W] || sat_lift) ? ST_SAT : ST_OK;
		end
	end

	// ---------------- output register and skid entry ----------------
	res_t ob_res;

	ucp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_i   (dv_valid[QUO_W] && en),
		.res_i     (res_d),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_o     (ob_res),
		.full      (buf_full)
	);

	assign out_x  = ob_res.x;
	assign out_y  = ob_res.y;
	assign out_z  = ob_res.z;
	assign status = ob_res.status;

endmodule

// ----- sv/ucp_sqrt_cell.sv -----
module ucp_sqrt_cell import ucp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_i,
	input  sq_side_t            side_i,
	input  logic [RAD_W-1:0]    rad_i,
	input  logic [SQ_REM_W-1:0] rem_i,
	input  logic [ROOT_W-1:0]   root_i,
	output logic                valid_s1,
	output sq_side_t            side_s1,
	output logic [RAD_W-1:0]    rad_s1,
	output logic [SQ_REM_W-1:0] rem_s1,
	output logic [ROOT_W-1:0]   root_s1
);

	logic [SQ_REM_W+1:0] rem_sh;
	logic [SQ_REM_W+1:0] trial;
	logic                take;

	// Bring down the next radicand bit pair and try the next root bit
	assign rem_sh = {rem_i, rad_i[RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_i, 2'b01};
	assign take   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	// Advance the partial root and remainder
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_i;
			rad_s1  <= {rad_i[RAD_W-3:0], 2'b00};
			rem_s1  <= take ? SQ_REM_W'(rem_sh - trial) : rem_sh[SQ_REM_W-1:0];
			root_s1 <= {root_i[ROOT_W-2:0], take};
		end
	end

endmodule

// ----- sv/ucp_div_cell.sv -----
module ucp_div_cell import ucp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_i,
	input  div_side_t        side_i,
	input  logic [DIV_W-1:0] dvs_i,
	input  div_lane_t [2:0]  lane_i,
	output logic             valid_s1,
	output div_side_t        side_s1,
	output logic [DIV_W-1:0] dvs_s1,
	output div_lane_t [2:0]  lane_s1
);

	logic [DIV_W:0]  sh [3];
	logic [2:0]      take;
	div_lane_t [2:0] nxt;

	// One quotient bit per lane against the shared divisor
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh[i]       = {lane_i[i].rem, lane_i[i].low[QUO_W-1]};
			take[i]     = (sh[i] >= {1'b0, dvs_i});
			nxt[i].rem  = take[i] ? DIV_W'(sh[i] - {1'b0, dvs_i}) : sh[i][DIV_W-1:0];
			nxt[i].low  = {lane_i[i].low[QUO_W-2:0], 1'b0};
			nxt[i].quo  = {lane_i[i].quo[QUO_W-2:0], take[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	// Hand the lanes to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_i;
			dvs_s1  <= dvs_i;
			lane_s1 <= nxt;
		end
	end

endmodule

// ----- sv/ucp_out_buf.sv -----
module ucp_out_buf import ucp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_i,
	input  res_t res_i,
	input  logic out_stall,
	output logic out_valid,
	output res_t res_o,
	output logic full
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_q;
	res_t skid_q;
	logic drain;

	assign drain     = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign res_o     = out_q;
	assign full      = skid_valid_q;

	// Control: refill the output from the skid entry first, else from the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			out_valid_q  <= skid_valid_q || valid_i;
			skid_valid_q <= 1'b0;
		end else if (valid_i) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (drain) begin
			out_q <= skid_valid_q ? skid_q : res_i;
		end else if (valid_i) begin
			skid_q <= res_i;
		end
	end

endmodule

// ----- sv/ucp_checker.sv -----
module ucp_checker import ucp_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [COORD_W-1:0] out_x,
	input logic signed [COORD_W-1:0] out_y,
	input logic signed [COORD_W-1:0] out_z,
	input logic [1:0]                status
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z) && $stable(status))
		else $error("stalled result changed");

	// Report only defined status codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_INVALID || status == ST_SAT))
		else $error("undefined status code");

	// Zero all coordinates of an invalid result
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_INVALID |-> out_x == '0 && out_y == '0 && out_z == '0)
		else $error("invalid result carries nonzero data");

	// Back-pressure only while a result waits
	a_stall_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(out_valid && out_stall))
		else $error("input stalled without an output stall");

endmodule

bind unified_camera_projection ucp_checker u_ucp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_x     (out_x),
	.out_y     (out_y),
	.out_z     (out_z),
	.status    (status)
);
